### rtl/icwp_pkg.sv
// Shared constants, register codes and types of the IR carrier waveform packer.
`timescale 1ns / 1ps
package icwp_pkg;

  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned POS_W           = $clog2(WORD_BITS);
  localparam int unsigned DUR_W           = 11;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned EFF_W           = DUR_W + 1;
  localparam int unsigned NUM_W           = DUR_W + 2;
  localparam int unsigned DIV_CNT_W       = $clog2(NUM_W + 1);
  localparam int unsigned MAX_DURATION_US = 2016;
  localparam int unsigned ADDR_W          = 4;
  localparam int unsigned DATA_W          = 32;

  localparam logic [CFG_W-1:0] PERIOD_RST = 6'd26;
  localparam logic [CFG_W-1:0] DUTY_RST   = 6'd9;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_DUTY   = 2'd1,
    REG_SOLUTION = 2'd2,
    REG_ROUND  = 2'd3
  } icwp_reg_e;

  typedef struct packed {
    logic [DUR_W-1:0] eff;
    logic             clip;
  } icwp_round_t;

endpackage

### rtl/icwp_in_if.sv
// Input channel: one duration word with valid/ready handshake.
`timescale 1ns / 1ps
interface icwp_in_if;
  logic                           valid;
  logic                           ready;
  logic [icwp_pkg::DUR_W-1:0]     duration_us;
  logic                           last_element;

  modport source (output valid, output duration_us, output last_element, input ready);
  modport sink   (input valid, input duration_us, input last_element, output ready);
endinterface

### rtl/icwp_out_if.sv
// Output channel: one packed waveform word with valid/ready handshake.
`timescale 1ns / 1ps
interface icwp_out_if;
  logic                             valid;
  logic                             ready;
  logic [icwp_pkg::WORD_BITS-1:0]   wave_word;
  logic                             word_last;
  logic                             clipped;

  modport source (output valid, output wave_word, output word_last, output clipped,
                  input ready);
  modport sink   (input valid, input wave_word, input word_last, input clipped,
                  output ready);
endinterface

### rtl/ir_carrier_waveform_packer.sv
// Top level: IR duration stream to packed one-bit-per-microsecond waveform words.
// Each element is first rounded (13-step serial divide plus hand-off), then expanded
// to one bit per microsecond of its rounded duration, then closed by a level toggle.
// A new element is accepted only in idle, after the previous one and any flush are done.
// Word emission stalls while the output register holds an untaken word.
// Reset (async, active low) restores register defaults and starts a new pattern.
`timescale 1ns / 1ps
module ir_carrier_waveform_packer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  icwp_in_if.sink                            in_i,
  icwp_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [icwp_pkg::ADDR_W-1:0]        paddr,
  input  logic [icwp_pkg::DATA_W-1:0]        pwdata,
  output logic [icwp_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ROUND  = 4'b0010,
    S_EXPAND = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_e;

  state_e                               state_q, state_d;
  logic [icwp_pkg::CFG_W-1:0]           period_q, duty_q;
  logic                                 sol_q, round_q;
  logic [icwp_pkg::CFG_W-1:0]           period_eff;
  icwp_pkg::icwp_reg_e                  reg_idx;
  logic                                 cfg_wr;

  logic                                 level_q, level_d;
  logic [icwp_pkg::POS_W-1:0]           pos_q, pos_d;
  logic [icwp_pkg::WORD_BITS-1:0]       word_q, word_d, word_set;
  logic                                 clip_q, clip_d;
  logic                                 last_q, last_d;
  logic [icwp_pkg::DUR_W-1:0]           cnt_q, cnt_d;
  logic [icwp_pkg::CFG_W-1:0]           phase_q, phase_d;

  logic                                 ovalid_q, ovalid_d;
  logic [icwp_pkg::WORD_BITS-1:0]       oword_q, oword_d;
  logic                                 olast_q, olast_d;
  logic                                 oclip_q, oclip_d;

  logic                                 in_acc, can_emit, word_full, bit_val;
  logic                                 rnd_done;
  icwp_pkg::icwp_round_t                rnd_res;

  assign period_eff = (period_q == '0) ? icwp_pkg::CFG_W'(1) : period_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign can_emit   = !ovalid_q || out_o.ready;
  assign word_full  = pos_q == icwp_pkg::POS_W'(icwp_pkg::WORD_BITS - 1);
  assign bit_val    = level_q && (!sol_q || (phase_q < duty_q));

  icwp_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .dur_i    (in_i.duration_us),
    .period_i (period_eff),
    .round_i  (round_q),
    .done_o   (rnd_done),
    .res_o    (rnd_res)
  );

  assign reg_idx = icwp_pkg::icwp_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      icwp_pkg::REG_PERIOD:   prdata = icwp_pkg::DATA_W'(period_q);
      icwp_pkg::REG_DUTY:     prdata = icwp_pkg::DATA_W'(duty_q);
      icwp_pkg::REG_SOLUTION: prdata = icwp_pkg::DATA_W'(sol_q);
      icwp_pkg::REG_ROUND:    prdata = icwp_pkg::DATA_W'(round_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= icwp_pkg::PERIOD_RST;
      duty_q   <= icwp_pkg::DUTY_RST;
      sol_q    <= 1'b0;
      round_q  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        icwp_pkg::REG_PERIOD:   period_q <= pwdata[icwp_pkg::CFG_W-1:0];
        icwp_pkg::REG_DUTY:     duty_q   <= pwdata[icwp_pkg::CFG_W-1:0];
        icwp_pkg::REG_SOLUTION: sol_q    <= pwdata[0];
        icwp_pkg::REG_ROUND:    round_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    pos_d    = pos_q;
    word_d   = word_q;
    clip_d   = clip_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    ovalid_d = ovalid_q && !out_o.ready;
    oword_d  = oword_q;
    olast_d  = olast_q;
    oclip_d  = oclip_q;
    word_set = word_q;
    word_set[pos_q] = word_q[pos_q] | bit_val;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d  = in_i.last_element;
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd_done) begin
          cnt_d   = rnd_res.eff;
          clip_d  = clip_q | rnd_res.clip;
          phase_d = '0;
          state_d = S_EXPAND;
        end
      end
      S_EXPAND: begin
        if (cnt_q != '0) begin
          if (!word_full || can_emit) begin
            cnt_d = cnt_q - 1'b1;
            if ({1'b0, phase_q} + 1'b1 >= {1'b0, period_eff}) begin
              phase_d = '0;
            end else begin
              phase_d = phase_q + 1'b1;
            end
            if (word_full) begin
              pos_d    = '0;
              word_d   = '0;
              ovalid_d = 1'b1;
              oword_d  = word_set;
              olast_d  = last_q && (cnt_q == icwp_pkg::DUR_W'(1));
              oclip_d  = clip_q;
            end else begin
              pos_d  = pos_q + 1'b1;
              word_d = word_set;
            end
          end
        end else begin
          level_d = !level_q;
          state_d = S_IDLE;
          if (last_q) begin
            if (pos_q != '0) begin
              state_d = S_FLUSH;
            end else begin
              level_d = 1'b1;
              word_d  = '0;
              clip_d  = 1'b0;
            end
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          ovalid_d = 1'b1;
          oword_d  = word_q;
          olast_d  = 1'b1;
          oclip_d  = clip_q;
          level_d  = 1'b1;
          pos_d    = '0;
          word_d   = '0;
          clip_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      level_q  <= 1'b1;
      pos_q    <= '0;
      word_q   <= '0;
      clip_q   <= 1'b0;
      last_q   <= 1'b0;
      cnt_q    <= '0;
      phase_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      pos_q    <= pos_d;
      word_q   <= word_d;
      clip_q   <= clip_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    olast_q <= olast_d;
    oclip_q <= oclip_d;
  end

  assign in_i.ready      = state_q == S_IDLE;
  assign out_o.valid     = ovalid_q;
  assign out_o.wave_word = oword_q;
  assign out_o.word_last = olast_q;
  assign out_o.clipped   = oclip_q;

endmodule

### rtl/icwp_round.sv
// Bit-serial rounding of a duration to whole carrier periods (when enabled), with saturation.
`timescale 1ns / 1ps
module icwp_round (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [icwp_pkg::DUR_W-1:0]   dur_i,
  input  logic [icwp_pkg::CFG_W-1:0]   period_i,
  input  logic                         round_i,
  output logic                         done_o,
  output icwp_pkg::icwp_round_t        res_o
);

  logic                                run_q, run_d;
  logic                                done_q, done_d;
  logic [icwp_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [icwp_pkg::NUM_W-1:0]          num_q, num_d;
  logic [icwp_pkg::CFG_W:0]            rem_q, rem_d;
  logic [icwp_pkg::CFG_W:0]            div_q, div_d;
  logic [icwp_pkg::DUR_W-1:0]          dur_q, dur_d;
  logic                                round_q, round_d;
  logic [icwp_pkg::CFG_W+1:0]          trial;
  logic [icwp_pkg::NUM_W-1:0]          diff;
  logic [icwp_pkg::EFF_W-1:0]          eff_full;
  logic                                clip;

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    div_d   = div_q;
    dur_d   = dur_q;
    round_d = round_q;
    trial   = {rem_q, num_q[icwp_pkg::NUM_W-1]};
    if (start_i) begin
      run_d   = 1'b1;
      cnt_d   = icwp_pkg::DIV_CNT_W'(icwp_pkg::NUM_W);
      num_d   = {1'b0, dur_i, 1'b0} + icwp_pkg::NUM_W'(period_i);
      rem_d   = '0;
      div_d   = {period_i, 1'b0};
      dur_d   = dur_i;
      round_d = round_i;
    end else if (run_q) begin
      num_d = {num_q[icwp_pkg::NUM_W-2:0], num_q[icwp_pkg::NUM_W-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = (icwp_pkg::CFG_W+1)'(trial - {1'b0, div_q});
      end else begin
        rem_d = (icwp_pkg::CFG_W+1)'(trial);
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == icwp_pkg::DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
    dur_q   <= dur_d;
    round_q <= round_d;
  end

  assign diff     = num_q - icwp_pkg::NUM_W'(rem_q);
  assign eff_full = round_q ? diff[icwp_pkg::NUM_W-1:1] : {1'b0, dur_q};
  assign clip     = eff_full > icwp_pkg::EFF_W'(icwp_pkg::MAX_DURATION_US);

  assign done_o     = done_q;
  assign res_o.clip = clip;
  assign res_o.eff  = clip ? icwp_pkg::DUR_W'(icwp_pkg::MAX_DURATION_US)
                           : eff_full[icwp_pkg::DUR_W-1:0];

endmodule

### rtl/icwp_chk.sv
// Port-level checker for the IR carrier waveform packer, bound to the top level.
`timescale 1ns / 1ps
module icwp_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [icwp_pkg::WORD_BITS-1:0]     wave_word_i,
  input logic                               word_last_i,
  input logic                               clipped_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({wave_word_i, word_last_i, clipped_i}))
    else $error("stalled word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after accept");

  a_round_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##10 !in_ready_i)
    else $error("input ready before rounding finished");

endmodule

bind ir_carrier_waveform_packer icwp_chk u_icwp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .wave_word_i (out_o.wave_word),
  .word_last_i (out_o.word_last),
  .clipped_i   (out_o.clipped)
);
